>>> rtl/mtav_pkg.sv
// Package for the multi-turn angle and velocity tracker.
// Holds the widths, the codes, the sequencer states and the structs used between modules.
// Depends on nothing.
package mtav_pkg;

    localparam int RAW_BITS   = 16;
    localparam int TIMER_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_W    = 48;
    localparam int VEL_W      = 32;
    localparam int TURN_W     = 32;
    localparam int CPR_W      = 17;
    localparam int TPU_W      = 8;
    localparam int FUNC_W     = 2;

    localparam int US_PER_S      = 1000000;
    localparam int US_PER_HALF_S = 500000;
    localparam int MS_PER_S      = 1000;

    localparam int CPR_RESET = 16384;
    localparam int TPU_RESET = 21;

    localparam int K_W   = $clog2(US_PER_S * ((1 << TPU_W) - 1) + 1);
    localparam int LIM_W = $clog2(US_PER_HALF_S * ((1 << TPU_W) - 1) + 1);

    localparam int ELAPSED_W = TIMER_BITS + 1;
    localparam int CMP_W     = (LIM_W > ELAPSED_W) ? LIM_W : ELAPSED_W;
    localparam int DVS_W     = (CPR_W > ELAPSED_W) ? CPR_W : ELAPSED_W;
    localparam int REM_W     = DVS_W + 1;
    localparam int WRAP_W    = ((RAW_BITS + 3) > (CPR_W + 2)) ? (RAW_BITS + 3) : (CPR_W + 2);

    localparam int ADIV_STEPS = RAW_BITS + FRAC_BITS;
    localparam int VDIV_STEPS = VEL_W;
    localparam int QUO_W      = (ADIV_STEPS > VDIV_STEPS) ? ADIV_STEPS : VDIV_STEPS;
    localparam int STEP_MAX   = (QUO_W > K_W) ? QUO_W : K_W;
    localparam int CNT_W      = $clog2(STEP_MAX);

    localparam int ALU_W = ANGLE_W + K_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CPR_W;

    localparam int IN_TDATA_W  = ((RAW_BITS + TIMER_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ANGLE_W + VEL_W + 7) / 8) * 8;
    localparam int TUSER_W     = FUNC_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_ANGLE = 2'd1,
        FUNC_VEL   = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPR = 1'b0,
        CFG_TPU = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRACK,
        S_ADIV,
        S_ANGLE,
        S_DIFF,
        S_ABS,
        S_MUL,
        S_OVF,
        S_VDIV,
        S_SAT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CPR_W-1:0] cpr;
        logic [TPU_W-1:0] tpu;
    } t_cfg;

    typedef struct packed {
        t_func                  func;
        logic [RAW_BITS-1:0]    raw;
        logic [TIMER_BITS-1:0]  now;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [VEL_W-1:0]   velocity;
    } t_result;

    typedef struct packed {
        logic start;
        logic out_free;
    } t_core_ctl;

    typedef struct packed {
        logic ready;
        logic done;
    } t_core_sts;

endpackage

>>> rtl/mtav_alu.sv
// Shared add/subtract unit of the tracker, used by the arithmetic steps.
// Depends on mtav_pkg.
module mtav_alu (
    input  logic [mtav_pkg::ALU_W-1:0] i_a,
    input  logic [mtav_pkg::ALU_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [mtav_pkg::ALU_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [mtav_pkg::ALU_W-1:0] b_eff;
    logic [mtav_pkg::ALU_W:0]   full;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign full  = {1'b0, i_a} + {1'b0, b_eff} + {{mtav_pkg::ALU_W{1'b0}}, i_sub};

    // on subtract, carry set means no borrow (a >= b)
    assign o_sum   = full[mtav_pkg::ALU_W-1:0];
    assign o_carry = full[mtav_pkg::ALU_W];

endmodule

>>> rtl/mtav_core.sv
// Sequencer and state registers of the tracker: unwrap, angle division,
// shift-add multiply and velocity division; most steps after unwrap share one mtav_alu.
// Depends on mtav_pkg and mtav_alu.
module mtav_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtav_pkg::t_core_ctl i_ctl,
    input  mtav_pkg::t_item     i_item,
    input  mtav_pkg::t_cfg      i_cfg,
    output mtav_pkg::t_core_sts o_sts,
    output mtav_pkg::t_result   o_result
);

    mtav_pkg::t_state r_state, n_state;

    mtav_pkg::t_func                   r_func;
    logic [mtav_pkg::RAW_BITS-1:0]     r_raw;
    logic [mtav_pkg::TIMER_BITS-1:0]   r_now;

    logic [mtav_pkg::RAW_BITS-1:0]     r_prev_raw;
    logic [mtav_pkg::TURN_W-1:0]       r_turn;
    logic [mtav_pkg::ANGLE_W-1:0]      r_prev_angle;
    logic [mtav_pkg::TIMER_BITS-1:0]   r_prev_ts;

    logic [mtav_pkg::CNT_W-1:0]        r_cnt;
    logic [mtav_pkg::REM_W-1:0]        r_rem;
    logic [mtav_pkg::QUO_W-1:0]        r_quo;
    logic [mtav_pkg::ANGLE_W-1:0]      r_angle;
    logic [mtav_pkg::ANGLE_W-1:0]      r_mag;
    logic                              r_neg;
    logic [mtav_pkg::DVS_W-1:0]        r_div;
    logic [mtav_pkg::K_W-1:0]          r_mult;
    logic [mtav_pkg::ALU_W-1:0]        r_acc;
    logic                              r_ovf;
    logic [mtav_pkg::VEL_W-1:0]        r_vel;

    logic [mtav_pkg::ALU_W-1:0]        alu_a, alu_b, alu_sum;
    logic                              alu_sub, alu_carry;

    logic [mtav_pkg::CPR_W-1:0]        cpr_eff;
    logic [mtav_pkg::DVS_W-1:0]        divisor;
    logic [mtav_pkg::REM_W-1:0]        div_t;

    logic                              up;
    logic [mtav_pkg::RAW_BITS-1:0]     raw_mag;
    logic [mtav_pkg::WRAP_W-1:0]       mag5, cpr4;
    logic                              wrap;

    logic                              now_lt;
    logic [mtav_pkg::TIMER_BITS-1:0]   now_inv;
    logic [mtav_pkg::ELAPSED_W-1:0]    elapsed;
    logic [mtav_pkg::LIM_W-1:0]        limit;
    logic                              forced;
    logic [mtav_pkg::K_W-1:0]          k_scale;

    logic [mtav_pkg::VDIV_STEPS-1:0]   vq;
    logic [mtav_pkg::VEL_W-1:0]        vel_sat;

    mtav_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // unwrap decision
    assign up      = r_raw > r_prev_raw;
    assign raw_mag = up ? (r_raw - r_prev_raw) : (r_prev_raw - r_raw);
    assign mag5    = mtav_pkg::WRAP_W'({raw_mag, 2'b00}) + mtav_pkg::WRAP_W'(raw_mag);
    assign cpr4    = mtav_pkg::WRAP_W'({i_cfg.cpr, 2'b00});
    assign wrap    = mag5 > cpr4;

    assign cpr_eff = (i_cfg.cpr == '0) ? mtav_pkg::CPR_W'(1) : i_cfg.cpr;

    // elapsed ticks of the down-counter
    assign now_lt  = r_now < r_prev_ts;
    assign now_inv = ~r_now;
    assign elapsed = now_lt ? mtav_pkg::ELAPSED_W'(r_prev_ts - r_now)
                            : mtav_pkg::ELAPSED_W'(now_inv) + mtav_pkg::ELAPSED_W'(r_prev_ts);
    assign limit   = mtav_pkg::LIM_W'(mtav_pkg::LIM_W'(mtav_pkg::US_PER_HALF_S)
                                      * mtav_pkg::LIM_W'(i_cfg.tpu));
    assign forced  = (elapsed == '0)
                     || (mtav_pkg::CMP_W'(elapsed) > mtav_pkg::CMP_W'(limit));
    assign k_scale = mtav_pkg::K_W'(mtav_pkg::K_W'(mtav_pkg::US_PER_S)
                                    * mtav_pkg::K_W'(i_cfg.tpu));

    assign divisor = (r_state == mtav_pkg::S_ADIV) ? mtav_pkg::DVS_W'(cpr_eff) : r_div;
    assign div_t   = {r_rem[mtav_pkg::REM_W-2:0], r_quo[mtav_pkg::QUO_W-1]};

    // saturation
    assign vq = r_quo[mtav_pkg::VDIV_STEPS-1:0];
    always_comb begin
        if (r_neg) begin
            if (r_ovf || (mtav_pkg::VEL_W'(vq) > {1'b1, {(mtav_pkg::VEL_W-1){1'b0}}})) begin
                vel_sat = {1'b1, {(mtav_pkg::VEL_W-1){1'b0}}};
            end else begin
                vel_sat = mtav_pkg::VEL_W'(0) - mtav_pkg::VEL_W'(vq);
            end
        end else begin
            if (r_ovf || vq[mtav_pkg::VDIV_STEPS-1]) begin
                vel_sat = {1'b0, {(mtav_pkg::VEL_W-1){1'b1}}};
            end else begin
                vel_sat = mtav_pkg::VEL_W'(vq);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtav_pkg::S_IDLE:  if (i_ctl.start) n_state = mtav_pkg::S_TRACK;
            mtav_pkg::S_TRACK: begin
                n_state = (r_func == mtav_pkg::FUNC_NONE) ? mtav_pkg::S_DONE : mtav_pkg::S_ADIV;
            end
            mtav_pkg::S_ADIV: begin
                if (r_cnt == mtav_pkg::CNT_W'(mtav_pkg::ADIV_STEPS - 1)) n_state = mtav_pkg::S_ANGLE;
            end
            mtav_pkg::S_ANGLE: begin
                n_state = (r_func == mtav_pkg::FUNC_VEL) ? mtav_pkg::S_DIFF : mtav_pkg::S_DONE;
            end
            mtav_pkg::S_DIFF:  n_state = mtav_pkg::S_ABS;
            mtav_pkg::S_ABS:   n_state = mtav_pkg::S_MUL;
            mtav_pkg::S_MUL: begin
                if (r_cnt == mtav_pkg::CNT_W'(mtav_pkg::K_W - 1)) n_state = mtav_pkg::S_OVF;
            end
            mtav_pkg::S_OVF: begin
                n_state = alu_carry ? mtav_pkg::S_SAT : mtav_pkg::S_VDIV;
            end
            mtav_pkg::S_VDIV: begin
                if (r_cnt == mtav_pkg::CNT_W'(mtav_pkg::VDIV_STEPS - 1)) n_state = mtav_pkg::S_SAT;
            end
            mtav_pkg::S_SAT:   n_state = mtav_pkg::S_DONE;
            mtav_pkg::S_DONE:  if (i_ctl.out_free) n_state = mtav_pkg::S_IDLE;
            default:           n_state = mtav_pkg::S_IDLE;
        endcase
    end

    // outputs and shared unit operands
    always_comb begin
        o_sts.ready = (r_state == mtav_pkg::S_IDLE);
        o_sts.done  = (r_state == mtav_pkg::S_DONE) && i_ctl.out_free;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            mtav_pkg::S_ADIV, mtav_pkg::S_VDIV: begin
                alu_a   = mtav_pkg::ALU_W'(div_t);
                alu_b   = mtav_pkg::ALU_W'(divisor);
                alu_sub = 1'b1;
            end
            mtav_pkg::S_ANGLE: begin
                alu_a = mtav_pkg::ALU_W'(mtav_pkg::ANGLE_W'({r_turn, {mtav_pkg::FRAC_BITS{1'b0}}}));
                alu_b = mtav_pkg::ALU_W'(r_quo[mtav_pkg::ADIV_STEPS-1:0]);
            end
            mtav_pkg::S_DIFF: begin
                alu_a   = mtav_pkg::ALU_W'(r_angle);
                alu_b   = mtav_pkg::ALU_W'(r_prev_angle);
                alu_sub = 1'b1;
            end
            mtav_pkg::S_ABS: begin
                alu_b   = mtav_pkg::ALU_W'(r_mag);
                alu_sub = 1'b1;
            end
            mtav_pkg::S_MUL: begin
                alu_a = {r_acc[mtav_pkg::ALU_W-2:0], 1'b0};
                alu_b = r_mult[mtav_pkg::K_W-1] ? mtav_pkg::ALU_W'(r_mag) : '0;
            end
            mtav_pkg::S_OVF: begin
                alu_a   = mtav_pkg::ALU_W'(r_acc[mtav_pkg::ALU_W-1:mtav_pkg::VEL_W]);
                alu_b   = mtav_pkg::ALU_W'(r_div);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign o_result.angle    = (r_func == mtav_pkg::FUNC_NONE) ? r_prev_angle : r_angle;
    assign o_result.velocity = (r_func == mtav_pkg::FUNC_VEL) ? r_vel : '0;

    // sequencer and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mtav_pkg::S_IDLE;
            r_prev_raw   <= '0;
            r_turn       <= '0;
            r_prev_angle <= '0;
            r_prev_ts    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                mtav_pkg::S_TRACK: begin
                    case (r_func)
                        mtav_pkg::FUNC_INIT: begin
                            r_prev_raw <= r_raw;
                            r_turn     <= '0;
                            r_prev_ts  <= r_now;
                        end
                        mtav_pkg::FUNC_ANGLE, mtav_pkg::FUNC_VEL: begin
                            r_prev_raw <= r_raw;
                            if (wrap) begin
                                r_turn <= up ? (r_turn - 1'b1) : (r_turn + 1'b1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                mtav_pkg::S_ANGLE: begin
                    if (r_func == mtav_pkg::FUNC_INIT) begin
                        r_prev_angle <= alu_sum[mtav_pkg::ANGLE_W-1:0];
                    end
                end
                mtav_pkg::S_SAT: begin
                    r_prev_angle <= r_angle;
                    r_prev_ts    <= r_now;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mtav_pkg::S_IDLE: begin
                if (i_ctl.start) begin
                    r_func <= i_item.func;
                    r_raw  <= i_item.raw;
                    r_now  <= i_item.now;
                end
            end
            mtav_pkg::S_TRACK: begin
                r_rem <= '0;
                r_quo <= mtav_pkg::QUO_W'({r_raw, {mtav_pkg::FRAC_BITS{1'b0}}})
                         << (mtav_pkg::QUO_W - mtav_pkg::ADIV_STEPS);
                r_cnt <= '0;
            end
            mtav_pkg::S_ADIV, mtav_pkg::S_VDIV: begin
                r_rem <= alu_carry ? alu_sum[mtav_pkg::REM_W-1:0] : div_t;
                r_quo <= {r_quo[mtav_pkg::QUO_W-2:0], alu_carry};
                r_cnt <= r_cnt + 1'b1;
            end
            mtav_pkg::S_ANGLE: begin
                r_angle <= alu_sum[mtav_pkg::ANGLE_W-1:0];
            end
            mtav_pkg::S_DIFF: begin
                r_mag  <= alu_sum[mtav_pkg::ANGLE_W-1:0];
                r_neg  <= alu_sum[mtav_pkg::ANGLE_W-1];
                r_div  <= forced ? mtav_pkg::DVS_W'(1) : mtav_pkg::DVS_W'(elapsed);
                r_mult <= forced ? mtav_pkg::K_W'(mtav_pkg::MS_PER_S) : k_scale;
            end
            mtav_pkg::S_ABS: begin
                if (r_neg) begin
                    r_mag <= alu_sum[mtav_pkg::ANGLE_W-1:0];
                end
                r_acc <= '0;
                r_cnt <= '0;
            end
            mtav_pkg::S_MUL: begin
                r_acc  <= alu_sum;
                r_mult <= {r_mult[mtav_pkg::K_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            mtav_pkg::S_OVF: begin
                r_ovf <= alu_carry;
                r_rem <= r_acc[mtav_pkg::VEL_W +: mtav_pkg::REM_W];
                r_quo <= mtav_pkg::QUO_W'(r_acc[mtav_pkg::VEL_W-1:0])
                         << (mtav_pkg::QUO_W - mtav_pkg::VDIV_STEPS);
                r_cnt <= '0;
            end
            mtav_pkg::S_SAT: begin
                r_vel <= vel_sat;
            end
            default: begin
            end
        endcase
    end

    a_ready_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_sts.ready && o_sts.done))
        else $error("core ready while delivering a result");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> !o_sts.ready)
        else $error("core still ready after taking an item");

    a_vel_only_func2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.done && (r_func != mtav_pkg::FUNC_VEL)) |-> (o_result.velocity == '0))
        else $error("non-zero velocity outside velocity read");

endmodule

>>> rtl/multi_turn_angle_velocity_tracker.sv
// Top level of the multi-turn angle and velocity tracker: stream ports,
// configuration registers and the result register. Depends on mtav_pkg and mtav_core.
// Init and angle reads run 32 angle-divider steps; velocity reads add 28 multiply
// steps and 32 velocity-divider steps, skipped on a saturated quotient.
// One item at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset clears the tracker state and loads register defaults.
module multi_turn_angle_velocity_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mtav_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // raw_count, timer_value
    input  logic [mtav_pkg::TUSER_W-1:0]        s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mtav_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // angle, velocity
    input  logic                                i_cfg_we,
    input  logic [mtav_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtav_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [mtav_pkg::CPR_W-1:0]        r_cpr;
    logic [mtav_pkg::TPU_W-1:0]        r_tpu;
    logic                              r_out_valid;
    logic [mtav_pkg::OUT_TDATA_W-1:0]  r_out_data;

    mtav_pkg::t_core_ctl ctl;
    mtav_pkg::t_core_sts sts;
    mtav_pkg::t_item     item;
    mtav_pkg::t_cfg      cfg;
    mtav_pkg::t_result   res;

    assign item.func = mtav_pkg::t_func'(s_axis_tuser[mtav_pkg::FUNC_W-1:0]);
    assign item.raw  = s_axis_tdata[mtav_pkg::RAW_BITS-1:0];
    assign item.now  = s_axis_tdata[mtav_pkg::RAW_BITS +: mtav_pkg::TIMER_BITS];

    assign cfg.cpr = r_cpr;
    assign cfg.tpu = r_tpu;

    assign s_axis_tready = sts.ready;
    assign ctl.start     = s_axis_tvalid && sts.ready;
    assign ctl.out_free  = !r_out_valid || m_axis_tready;

    mtav_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_sts    (sts),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr <= mtav_pkg::CPR_W'(mtav_pkg::CPR_RESET);
            r_tpu <= mtav_pkg::TPU_W'(mtav_pkg::TPU_RESET);
        end else if (i_cfg_we) begin
            case (mtav_pkg::t_cfg_idx'(i_cfg_index))
                mtav_pkg::CFG_CPR: r_cpr <= i_cfg_data[mtav_pkg::CPR_W-1:0];
                mtav_pkg::CFG_TPU: r_tpu <= i_cfg_data[mtav_pkg::TPU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sts.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sts.done) begin
            r_out_data <= mtav_pkg::OUT_TDATA_W'({res.velocity, res.angle});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
